>>> src/wnn_pkg.sv
// ----------------------------------------------------------------------------
// wnn_pkg
// Shared types, constants and helpers of the weighted nearest-neighbor search.
// ----------------------------------------------------------------------------
package wnn_pkg;

  localparam int REF_DEPTH_DEF    = 1024;
  localparam int FEATURE_BITS_DEF = 20;

  localparam int NUM_FEAT    = 6;
  localparam int PORT_FEAT_W = 20;
  localparam int MAX_FEAT_W  = 24;
  localparam int WEIGHT_W    = 16;
  localparam int COUNT_W     = 11;
  localparam int ENTRY_W     = 10;
  localparam int OUT_IDX_W   = 10;
  localparam int IDX_MAX_W   = 16;
  localparam int DIST_W      = 61;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int LANE_LAT = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PHI      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THETA    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LENGTH   = 3'd6;

  // Input commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_FEAT] = '{
    16'd65535, 16'd65535, 16'd65535, 16'd10430, 16'd10430, 16'd65535
  };

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [IDX_MAX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic clear;
    tag_t tag;
  } mrg_ctrl_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [IDX_MAX_W-1:0] idx;
    logic [DIST_W-1:0]    distance;
  } mrg_res_t;

  typedef logic [DIST_W-1:0] dist_t;

  // Saturating add of two distances.
  function automatic dist_t sat_add(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

>>> src/wnn_lane.sv
// ----------------------------------------------------------------------------
// wnn_lane
// One feature lane: difference, square and weighting in three stages.
// ----------------------------------------------------------------------------
module wnn_lane
  import wnn_pkg::*;
#(
  parameter int FEATURE_BITS = FEATURE_BITS_DEF
) (
  input  logic                           clk,
  input  logic signed [FEATURE_BITS-1:0] qry_feat,
  input  logic signed [FEATURE_BITS-1:0] ref_feat,
  input  logic [WEIGHT_W-1:0]            weight,
  output logic [DIST_W-1:0]              term
);

  localparam int MAG_W  = FEATURE_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int PROD_W = SQ_W + WEIGHT_W;
  localparam int CMP_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag_nxt;
  logic [MAG_W-1:0]        mag_r;
  logic [SQ_W-1:0]         sq_r;
  logic [PROD_W-1:0]       prod;
  logic [CMP_W-1:0]        prod_ext;
  logic [DIST_W-1:0]       term_nxt;
  logic [DIST_W-1:0]       term_r;

  always_comb begin
    diff     = MAG_W'(qry_feat) - MAG_W'(ref_feat);
    mag_nxt  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    prod     = PROD_W'(sq_r) * PROD_W'(weight);
    prod_ext = CMP_W'(prod);
    term_nxt = (prod_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : prod_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    sq_r   <= SQ_W'(mag_r) * SQ_W'(mag_r);
    term_r <= term_nxt;
  end

  assign term = term_r;

endmodule

>>> src/wnn_merge.sv
// ----------------------------------------------------------------------------
// wnn_merge
// Adds the six lane terms in a registered tree and keeps the best record.
// ----------------------------------------------------------------------------
module wnn_merge
  import wnn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mrg_ctrl_t         ctrl,
  input  logic [DIST_W-1:0] terms [NUM_FEAT],
  output mrg_res_t          res
);

  logic [DIST_W-1:0]    s01_r, s23_r, s45_r;
  logic [DIST_W-1:0]    s0123_r, s45b_r;
  logic [DIST_W-1:0]    total_r;
  tag_t                 tag1_r, tag2_r, tag3_r;
  logic                 found_r;
  logic                 done_r;
  logic [IDX_MAX_W-1:0] best_idx_r;
  logic [DIST_W-1:0]    best_dist_r;

  always_ff @(posedge clk) begin
    s01_r   <= sat_add(terms[0], terms[1]);
    s23_r   <= sat_add(terms[2], terms[3]);
    s45_r   <= sat_add(terms[4], terms[5]);
    s0123_r <= sat_add(s01_r, s23_r);
    s45b_r  <= s45_r;
    total_r <= sat_add(s0123_r, s45b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r  <= '0;
      tag2_r  <= '0;
      tag3_r  <= '0;
      found_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      tag1_r <= ctrl.tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      done_r <= tag3_r.valid && tag3_r.last;
      // Strict compare keeps the lowest index among equal distances.
      if (ctrl.clear) begin
        found_r <= 1'b0;
      end else if (tag3_r.valid && (!found_r || total_r < best_dist_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && tag3_r.valid && (!found_r || total_r < best_dist_r)) begin
      best_idx_r  <= tag3_r.idx;
      best_dist_r <= total_r;
    end
  end

  assign res.done     = done_r;
  assign res.found    = found_r;
  assign res.idx      = best_idx_r;
  assign res.distance = best_dist_r;

endmodule

>>> src/weighted_nearest_neighbor_search_unit.sv
// ----------------------------------------------------------------------------
// weighted_nearest_neighbor_search_unit
// Reference table with a weighted squared-distance nearest-neighbor search.
// ----------------------------------------------------------------------------
// Usage: the in_ channel carries load and query items. A load writes one
// record into the reference memory; it gives no result. A query scans
// records 0 to N-1, N being ref_count limited to REF_DEPTH, one record per
// cycle through the single memory read port, six feature lanes and a
// registered adder tree. Its result appears on the out_ channel; a query
// with N of zero gives found=0. The next item is taken only once the
// result has moved to the output register.
// The out_ channel holds its result in a register: while the receiver
// stalls, loads and a further query are still taken, and a query that
// finishes before the held result is taken waits until it leaves.
// The cfg_ channel writes ref_count and the six weights; it is always ready
// and is meant to be used while no query is running.
// Reset clears the registers to their defaults and empties the pipeline.
// The reference memory is not cleared: records must be loaded before they
// are searched.
// ----------------------------------------------------------------------------
module weighted_nearest_neighbor_search_unit
  import wnn_pkg::*;
#(
  parameter int REF_DEPTH    = REF_DEPTH_DEF,
  parameter int FEATURE_BITS = FEATURE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [ENTRY_W-1:0]     in_entry_index,
  input  logic [PORT_FEAT_W-1:0] in_center_x,
  input  logic [PORT_FEAT_W-1:0] in_center_y,
  input  logic [PORT_FEAT_W-1:0] in_center_z,
  input  logic [PORT_FEAT_W-1:0] in_phi,
  input  logic [PORT_FEAT_W-1:0] in_theta,
  input  logic [PORT_FEAT_W-1:0] in_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_IDX_W-1:0]   out_best_index,
  output logic [DIST_W-1:0]      out_best_distance,
  output logic                   out_found
);

  localparam int IDX_W    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W    = $clog2(REF_DEPTH + 1);
  localparam int TAG_DEPTH = 1 + LANE_LAT;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_HOLD} state_t;

  typedef logic signed [FEATURE_BITS-1:0] feat_t;

  state_t                 state_r;
  logic [COUNT_W-1:0]     ref_count_r;
  logic [WEIGHT_W-1:0]    weight_r [NUM_FEAT];
  feat_t                  qry_r [NUM_FEAT];
  feat_t                  in_feat [NUM_FEAT];
  logic [PORT_FEAT_W-1:0] in_raw [NUM_FEAT];
  logic [MAX_FEAT_W-1:0]  raw_ext [NUM_FEAT];
  logic [NUM_FEAT-1:0][FEATURE_BITS-1:0] mem [REF_DEPTH];
  logic [NUM_FEAT-1:0][FEATURE_BITS-1:0] rd_data_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       rd_addr_r;
  logic                   empty_r;
  tag_t                   tag_pipe_r [TAG_DEPTH];
  tag_t                   issue_tag;
  mrg_ctrl_t              mrg_ctrl;
  mrg_res_t               mrg_res;
  logic [DIST_W-1:0]      terms [NUM_FEAT];
  logic                   in_xfer;
  logic                   load_wr;
  logic                   out_free;
  logic                   scan_last;
  logic [IDX_W-1:0]       wr_addr;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic [OUT_IDX_W-1:0]   out_best_index_r;
  logic [DIST_W-1:0]      out_best_distance_r;
  logic                   out_found_r;

  assign in_raw[0] = in_center_x;
  assign in_raw[1] = in_center_y;
  assign in_raw[2] = in_center_z;
  assign in_raw[3] = in_phi;
  assign in_raw[4] = in_theta;
  assign in_raw[5] = in_length;

  // Only the low FEATURE_BITS bits of a port carry the feature.
  always_comb begin
    for (int f = 0; f < NUM_FEAT; f++) begin
      raw_ext[f] = MAX_FEAT_W'(in_raw[f]);
      in_feat[f] = feat_t'(raw_ext[f][FEATURE_BITS-1:0]);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_wr   = in_xfer && (in_command == CMD_LOAD) &&
                     (32'(in_entry_index) < REF_DEPTH);
  assign wr_addr   = IDX_W'(in_entry_index);
  assign out_free  = !out_valid_r || out_ready;
  assign scan_last = (rd_addr_r == count_r - CNT_W'(1));
  assign count_nxt = (32'(ref_count_r) > REF_DEPTH) ? CNT_W'(REF_DEPTH)
                                                     : CNT_W'(ref_count_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= '0;
      for (int f = 0; f < NUM_FEAT; f++) begin
        weight_r[f] <= WEIGHT_RESET[f];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REF_COUNT:       ref_count_r <= cfg_data[COUNT_W-1:0];
        CFG_WEIGHT_CENTER_X: weight_r[0] <= cfg_data;
        CFG_WEIGHT_CENTER_Y: weight_r[1] <= cfg_data;
        CFG_WEIGHT_CENTER_Z: weight_r[2] <= cfg_data;
        CFG_WEIGHT_PHI:      weight_r[3] <= cfg_data;
        CFG_WEIGHT_THETA:    weight_r[4] <= cfg_data;
        CFG_WEIGHT_LENGTH:   weight_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reference memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      for (int f = 0; f < NUM_FEAT; f++) begin
        mem[wr_addr][f] <= in_feat[f];
      end
    end
    rd_data_r <= mem[rd_addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_command == CMD_QUERY)) begin
      for (int f = 0; f < NUM_FEAT; f++) begin
        qry_r[f] <= in_feat[f];
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_addr_r   <= '0;
      count_r     <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the hold phase the output valid is decided by that phase alone.
      if (out_valid_r && out_ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_command == CMD_QUERY)) begin
            rd_addr_r <= '0;
            count_r   <= count_nxt;
            empty_r   <= (count_nxt == '0);
            state_r   <= (count_nxt == '0) ? S_HOLD : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_addr_r <= rd_addr_r + CNT_W'(1);
          if (scan_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mrg_res.done) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_HOLD) && out_free) begin
      out_found_r         <= !empty_r && mrg_res.found;
      out_best_index_r    <= empty_r ? '0 : mrg_res.idx[OUT_IDX_W-1:0];
      out_best_distance_r <= empty_r ? '0 : mrg_res.distance;
    end
  end

  // Record tags follow the data through the memory read and the lanes.
  always_comb begin
    issue_tag.valid = (state_r == S_SCAN);
    issue_tag.last  = scan_last;
    issue_tag.idx   = IDX_MAX_W'(rd_addr_r[IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TAG_DEPTH; s++) begin
        tag_pipe_r[s] <= '0;
      end
    end else begin
      tag_pipe_r[0] <= issue_tag;
      for (int s = 1; s < TAG_DEPTH; s++) begin
        tag_pipe_r[s] <= tag_pipe_r[s-1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NUM_FEAT; g++) begin : g_lane
      wnn_lane #(
        .FEATURE_BITS(FEATURE_BITS)
      ) u_lane (
        .clk      (clk),
        .qry_feat (qry_r[g]),
        .ref_feat (feat_t'(rd_data_r[g])),
        .weight   (weight_r[g]),
        .term     (terms[g])
      );
    end
  endgenerate

  assign mrg_ctrl.clear = in_xfer && (in_command == CMD_QUERY);
  assign mrg_ctrl.tag   = tag_pipe_r[TAG_DEPTH-1];

  wnn_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mrg_ctrl),
    .terms (terms),
    .res   (mrg_res)
  );

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_best_index_r;
  assign out_best_distance = out_best_distance_r;
  assign out_found         = out_found_r;

  // The pipeline is empty whenever the block waits for a new item.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mrg_ctrl.tag.valid)
    else $error("record tag in flight while idle");

  // The last record of a scan is only merged after all reads were issued.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_res.done |-> (state_r == S_DRAIN))
    else $error("scan finished outside the drain phase");

  // Reads stay within the searched part of the table.
  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_addr_r < count_r))
    else $error("read address beyond record count");

  // A result is only presented from the hold phase.
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result presented outside the hold phase");

endmodule
